@@ rtl/core/lqma_pkg.sv @@
// lqma_pkg: shared types and constants of the link quality moving average
// used by lqma_cell, lqma_div and link_quality_moving_average; no dependencies

package lqma_pkg;

    // field widths
    localparam int PEND_W    = 8;
    localparam int ARR_W     = 8;
    localparam int SCALE_W   = 4;
    localparam int SAMPLE_W  = 7;
    localparam int QUALITY_W = 7;
    localparam int PROD_W    = ARR_W + SCALE_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_CAP     = 2'd2;

    // register reset values
    localparam logic [PEND_W-1:0]   BUSY_THRESHOLD_RST = 8'd190;
    localparam logic [SCALE_W-1:0]  SAMPLE_SCALE_RST   = 4'd10;
    localparam logic [SAMPLE_W-1:0] SAMPLE_CAP_RST     = 7'd100;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_DIVIDE
    } lqma_state_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } lqma_div_stat_t;

endpackage

@@ rtl/core/lqma_cell.sv @@
// lqma_cell: one sample slot of the sample chain
// depends on lqma_pkg

module lqma_cell
    import lqma_pkg::*;
(
    input  logic                aclk,
    input  logic                en,
    input  logic [SAMPLE_W-1:0] din,
    output logic [SAMPLE_W-1:0] dout
);

    logic [SAMPLE_W-1:0] data_reg;
    logic [SAMPLE_W-1:0] data_next;

    // take the neighbor's sample whenever the chain moves
    assign data_next = en ? din : data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign dout = data_reg;

endmodule

@@ rtl/core/lqma_div.sv @@
// lqma_div: iterative restoring divider, one quotient bit per cycle
// depends on lqma_pkg; quotient must fit in QUALITY_W bits

module lqma_div
    import lqma_pkg::*;
#(
    parameter int SUM_W = 11,
    parameter int DEN_W = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [SUM_W-1:0]     dividend,
    input  logic [DEN_W-1:0]     divisor,
    output logic [QUALITY_W-1:0] quotient,
    output lqma_div_stat_t       stat
);

    localparam int R_W    = DEN_W + 1;
    localparam int STEP_W = $clog2(QUALITY_W);

    logic [R_W-1:0]       rem_reg, rem_next;
    logic [QUALITY_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [R_W-1:0] trial;
    logic           fits;

    // quotient is known to be below 2^QUALITY_W, so the bits above start
    // out as the partial remainder, already below the divisor
    assign trial = {rem_reg[R_W-2:0], quo_reg[QUALITY_W-1]};
    assign fits  = trial >= R_W'(den_reg);

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            rem_next  = R_W'(dividend >> QUALITY_W);
            quo_next  = dividend[QUALITY_W-1:0];
            den_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            rem_next  = fits ? (trial - R_W'(den_reg)) : trial;
            quo_next  = {quo_reg[QUALITY_W-2:0], fits};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(QUALITY_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ rtl/core/link_quality_moving_average.sv @@
// link_quality_moving_average: top level of the link quality estimator
// depends on lqma_pkg, lqma_cell and lqma_div

// Each transfer on the s_ channel is one received pong reply carrying the
// device's pending pong count. An 8-bit arrival counter counts every reply.
// When the pending count is at or below busy_threshold and the counter is
// above 1, counter * sample_scale clipped to sample_cap enters a chain of
// RING_DEPTH sample cells (the oldest sample falls off the end), and the
// truncated mean of the stored samples goes out on the m_ channel; the
// counter clears whenever the pending count is at or below the threshold.
// A reply that takes no sample is done in its transfer cycle and s_ready
// stays high. A reply that takes a sample keeps s_ready low until its
// result is loaded into the m_ output register; to get there the
// chain rotates once through its RING_DEPTH cells to sum the samples, then
// an iterative divider yields one quality bit per cycle. The m_ output is
// registered, so a result waiting for m_ready does not hold off input
// until the next result is ready to go out. No clearing pass after reset.
// Configuration writes are taken in any cycle (cfg_ready is always high),
// but are meant only while the block is idle; index 3 is ignored.

module link_quality_moving_average
    import lqma_pkg::*;
#(
    parameter int RING_DEPTH = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PEND_W-1:0]     s_pending_count,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [QUALITY_W-1:0]  m_quality,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = $clog2(RING_DEPTH * ((1 << SAMPLE_W) - 1) + 1);

    // configuration registers
    logic [PEND_W-1:0]   busy_threshold_reg, busy_threshold_next;
    logic [SCALE_W-1:0]  sample_scale_reg, sample_scale_next;
    logic [SAMPLE_W-1:0] sample_cap_reg, sample_cap_next;

    // control state
    lqma_state_t         state_reg, state_next;
    logic [ARR_W-1:0]    arrival_counter_reg, arrival_counter_next;
    logic [CNT_W-1:0]    fill_count_reg, fill_count_next;
    logic [CNT_W-1:0]    step_reg, step_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic                m_valid_reg, m_valid_next;
    logic [QUALITY_W-1:0] m_quality_reg, m_quality_next;

    // datapath
    logic                 in_xfer;
    logic [ARR_W-1:0]     counter_inc;
    logic                 below_threshold;
    logic                 take_sample;
    logic [PROD_W-1:0]    product;
    logic [SAMPLE_W-1:0]  sample;
    logic                 step_last;
    logic                 slot_filled;
    logic                 chain_en;
    logic [SAMPLE_W-1:0]  chain_din;
    logic [SAMPLE_W-1:0]  cell_q [RING_DEPTH];
    logic [SAMPLE_W-1:0]  tail;
    logic                 div_start;
    logic [QUALITY_W-1:0] div_quotient;
    lqma_div_stat_t       div_stat;
    logic                 out_load;

    // ---------------- configuration port ----------------
    assign cfg_ready = 1'b1;

    always_comb begin
        busy_threshold_next = busy_threshold_reg;
        sample_scale_next   = sample_scale_reg;
        sample_cap_next     = sample_cap_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_BUSY_THRESHOLD: busy_threshold_next = cfg_data;
                CFG_SAMPLE_SCALE:   sample_scale_next   = cfg_data[SCALE_W-1:0];
                CFG_SAMPLE_CAP:     sample_cap_next     = cfg_data[SAMPLE_W-1:0];
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // ---------------- sample forming ----------------
    assign in_xfer         = s_valid && s_ready;
    assign counter_inc     = arrival_counter_reg + ARR_W'(1);
    assign below_threshold = s_pending_count <= busy_threshold_reg;
    // a sample needs a quiet device and an arrival count, this reply included, above 1
    assign take_sample     = in_xfer && below_threshold && (counter_inc > ARR_W'(1));

    assign product = PROD_W'(counter_inc) * PROD_W'(sample_scale_reg);
    // clip to the cap
    assign sample  = (product > PROD_W'(sample_cap_reg)) ? sample_cap_reg
                                                        : product[SAMPLE_W-1:0];

    // ---------------- sample chain ----------------
    // a new sample shifts in at cell 0; during the sum the chain rotates
    // tail back to head, so after RING_DEPTH steps it is back in place
    assign tail = cell_q[RING_DEPTH-1];

    for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
        lqma_cell u_cell (
            .aclk (aclk),
            .en   (chain_en),
            .din  ((i == 0) ? chain_din : cell_q[(i == 0) ? 0 : i - 1]),
            .dout (cell_q[i])
        );
    end

    // at rotation step k the tail holds cell RING_DEPTH-1-k of the chain,
    // which is filled when k + fill_count reaches RING_DEPTH
    assign step_last   = step_reg == CNT_W'(RING_DEPTH - 1);
    assign slot_filled = ({1'b0, step_reg} + {1'b0, fill_count_reg})
                         >= (CNT_W + 1)'(RING_DEPTH);

    // ---------------- divider ----------------
    lqma_div #(
        .SUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_next),
        .divisor  (fill_count_reg),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take_sample) begin
                    state_next = ST_ROTATE;
                end
            end
            ST_ROTATE: begin
                if (step_last) begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        chain_en  = 1'b0;
        chain_din = sample;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                chain_en = take_sample;
            end
            ST_ROTATE: begin
                chain_en  = 1'b1;
                chain_din = tail;
                // last step feeds the finished sum straight to the divider
                div_start = step_last;
            end
            ST_DIVIDE: begin
                // result waits in the divider until the output register frees
                out_load = div_stat.done && (!m_valid_reg || m_ready);
            end
            default: begin
            end
        endcase
    end

    // counters, accumulator and output register
    always_comb begin
        arrival_counter_next = arrival_counter_reg;
        fill_count_next      = fill_count_reg;
        step_next            = step_reg;
        acc_next             = acc_reg;
        m_valid_next         = m_valid_reg;
        m_quality_next       = m_quality_reg;

        if (in_xfer) begin
            arrival_counter_next = below_threshold ? '0 : counter_inc;
        end

        if (take_sample) begin
            if (fill_count_reg < CNT_W'(RING_DEPTH)) begin
                fill_count_next = fill_count_reg + CNT_W'(1);
            end
            step_next = '0;
            acc_next  = '0;
        end else if (state_reg == ST_ROTATE) begin
            step_next = step_reg + CNT_W'(1);
            acc_next  = acc_reg + (slot_filled ? SUM_W'(tail) : '0);
        end

        if (out_load) begin
            m_valid_next   = 1'b1;
            m_quality_next = div_quotient;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            arrival_counter_reg <= '0;
            fill_count_reg      <= '0;
            step_reg            <= '0;
            m_valid_reg         <= 1'b0;
            busy_threshold_reg  <= BUSY_THRESHOLD_RST;
            sample_scale_reg    <= SAMPLE_SCALE_RST;
            sample_cap_reg      <= SAMPLE_CAP_RST;
        end else begin
            state_reg           <= state_next;
            arrival_counter_reg <= arrival_counter_next;
            fill_count_reg      <= fill_count_next;
            step_reg            <= step_next;
            m_valid_reg         <= m_valid_next;
            busy_threshold_reg  <= busy_threshold_next;
            sample_scale_reg    <= sample_scale_next;
            sample_cap_reg      <= sample_cap_next;
        end
        acc_reg       <= acc_next;
        m_quality_reg <= m_quality_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_quality = m_quality_reg;

    // ---------------- assertions ----------------
    // fill count saturates at the chain length
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CNT_W'(RING_DEPTH))
        else $error("fill count beyond chain length");

    // a new result only comes out of the divide phase
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DIVIDE))
        else $error("result raised outside divide phase");

    // a reply from a quiet device always clears the arrival counter
    a_counter_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && below_threshold) |=> (arrival_counter_reg == '0))
        else $error("arrival counter not cleared");

    // while waiting on the divider it is either working or finished
    a_div_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE) |-> (div_stat.busy || div_stat.done))
        else $error("divider idle during divide phase");

    // never divide by an empty chain
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (fill_count_reg != '0))
        else $error("divide started with no samples");

endmodule

@@ tb/link_quality_checker.sv @@
`timescale 1ns / 1ps
// link_quality_checker: watches the pong, quality and register channels of
// link_quality_moving_average, predicts each quality result and compares it
// depends on lqma_pkg

module link_quality_checker
    import lqma_pkg::*;
#(
    parameter int RING_DEPTH = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [PEND_W-1:0]     s_pending_count,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [QUALITY_W-1:0]  m_quality,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    error_count,
    output int                    results_owed
);

    logic [PEND_W-1:0]    threshold;
    logic [SCALE_W-1:0]   scale;
    logic [SAMPLE_W-1:0]  cap;
    logic [ARR_W-1:0]     arrivals;
    logic [SAMPLE_W-1:0]  samples [RING_DEPTH];
    int                   wr_pos;
    int                   filled;
    logic [QUALITY_W-1:0] quality_due [$];

    // one pong reply: bump the arrival count, maybe store a sample and owe a result
    task automatic absorb_pong(input logic [PEND_W-1:0] pend);
        logic [PROD_W-1:0]   product;
        logic [SAMPLE_W-1:0] sample;
        int                  sum;
        arrivals = arrivals + 1'b1;
        if (pend <= threshold) begin
            if (arrivals > 1) begin
                product = arrivals * scale;
                sample  = (product > cap) ? cap : product[SAMPLE_W-1:0];
                samples[wr_pos] = sample;
                wr_pos = (wr_pos + 1) % RING_DEPTH;
                if (filled < RING_DEPTH)
                    filled++;
                sum = 0;
                for (int i = 0; i < filled; i++)
                    sum += samples[i];
                quality_due.push_back(QUALITY_W'(sum / filled));
            end
            arrivals = '0;
        end
    endtask

    always @(posedge aclk) begin
        logic [QUALITY_W-1:0] want;
        if (!aresetn) begin
            threshold   = BUSY_THRESHOLD_RST;
            scale       = SAMPLE_SCALE_RST;
            cap         = SAMPLE_CAP_RST;
            arrivals    = '0;
            wr_pos      = 0;
            filled      = 0;
            error_count = 0;
            quality_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (quality_due.size() == 0) begin
                    $error("unexpected quality result %0d with nothing expected", m_quality);
                    error_count++;
                end else begin
                    want = quality_due.pop_front();
                    if (m_quality !== want) begin
                        $error("quality mismatch: expected %0d, actual %0d", want, m_quality);
                        error_count++;
                    end
                end
            end
            // a reply in the same cycle as a register write still sees the old value
            if (s_valid && s_ready)
                absorb_pong(s_pending_count);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BUSY_THRESHOLD: threshold = cfg_data[PEND_W-1:0];
                    CFG_SAMPLE_SCALE:   scale     = cfg_data[SCALE_W-1:0];
                    CFG_SAMPLE_CAP:     cap       = cfg_data[SAMPLE_W-1:0];
                    default: ;
                endcase
            end
        end
        results_owed = quality_due.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench: drives pong replies and register writes into
// link_quality_moving_average and gives the verdict from link_quality_checker
// depends on lqma_pkg, link_quality_checker and the block itself

module testbench;
    import lqma_pkg::*;

    localparam int RING_DEPTH = 10;
    // the one index the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int ITEM_TARGET    = 1650;
    localparam int PHASE_ITEMS    = 120;
    localparam int SETTLE_CYCLES  = 2 * RING_DEPTH + 10;
    // early in the first random phase, so replies keep coming during the hold
    localparam int HOLD_AT_RESULT = 8;
    localparam int HOLD_CYCLES    = 300;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [PEND_W-1:0]     s_pending_count;
    logic                  m_valid;
    logic                  m_ready;
    logic [QUALITY_W-1:0]  m_quality;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int error_count;
    int results_owed;
    int items_sent;
    int results_taken;
    bit calm;                       // no sender gaps while set
    logic [PEND_W-1:0] cur_threshold;

    link_quality_moving_average #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pending_count (s_pending_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_quality       (m_quality),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    link_quality_checker #(
        .RING_DEPTH(RING_DEPTH)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pending_count (s_pending_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_quality       (m_quality),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .results_owed    (results_owed)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // hard stop in case a handshake never completes
    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    // idle lengths: mostly none or short, now and then a long one
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(10, 4);
        else
            return $urandom_range(40, 16);
    endfunction

    // pending count that keeps the device busy (above the threshold)
    function automatic logic [PEND_W-1:0] busy_count(input logic [PEND_W-1:0] thr);
        return PEND_W'($urandom_range(255, int'(thr) + 1));
    endfunction

    // pending count at or below the threshold, so a sample may be taken
    function automatic logic [PEND_W-1:0] free_count(input logic [PEND_W-1:0] thr);
        return PEND_W'($urandom_range(int'(thr), 0));
    endfunction

    // receiver: takes results with random stalls, plus one long hold-off
    // so the block's output register fills and s_ready drops
    initial begin
        int gap;
        m_ready       = 1'b0;
        results_taken = 0;
        forever begin
            @(negedge aclk);
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready && aresetn))
                @(posedge aclk);
            results_taken++;
            if (results_taken == HOLD_AT_RESULT)
                gap = HOLD_CYCLES;
            else if ((results_taken / 64) % 4 == 3)
                gap = 0;                    // stretch with ready held high
            else
                gap = gap_cycles();
            if (gap > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    end

    // one pong transfer; valid stays high into the next item when there is no gap
    task automatic send_pong(input logic [PEND_W-1:0] pend);
        int gap;
        gap = calm ? 0 : gap_cycles();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_pending_count <= pend;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_BUSY_THRESHOLD)
            cur_threshold = data;
    endtask

    // stop offering, let every owed result drain, then let the block settle
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // run of busy replies followed by one reply that may take a sample
    task automatic send_burst(input int busy_len);
        for (int i = 0; i < busy_len; i++)
            send_pong(busy_count(cur_threshold));
        send_pong(free_count(cur_threshold));
    endtask

    initial begin
        logic [PEND_W-1:0]   thr;
        logic [SCALE_W-1:0]  scl;
        logic [SAMPLE_W-1:0] cp;
        int                  phase;
        int                  phase_end;
        int                  len;

        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_pending_count = '0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_BUSY_THRESHOLD;
        cfg_data        = '0;
        items_sent      = 0;
        calm            = 1'b0;
        cur_threshold   = BUSY_THRESHOLD_RST;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: busy reply, first sample, threshold equality,
        // counter at 1 after a clear, then a longer busy run
        send_pong(8'd255);
        send_pong(8'd0);
        send_pong(8'd190);
        send_pong(8'd191);
        send_pong(8'd128);
        send_pong(8'd200);
        send_pong(8'd255);
        send_pong(8'd191);
        send_pong(8'd254);
        send_pong(8'd0);
        drain();

        // zero threshold, top scale and cap: sample clipped at 127,
        // each pending bit set on its own
        write_register(CFG_BUSY_THRESHOLD, 8'd0);
        write_register(CFG_SAMPLE_SCALE, 8'd15);
        write_register(CFG_SAMPLE_CAP, 8'd127);
        send_pong(8'd1);
        send_pong(8'd128);
        send_pong(8'd255);
        send_pong(8'd64);
        send_pong(8'd2);
        send_pong(8'd4);
        send_pong(8'd8);
        send_pong(8'd16);
        send_pong(8'd32);
        send_pong(8'd0);
        drain();

        // scale of zero, then cap of zero: each new sample is zero
        write_register(CFG_SAMPLE_SCALE, 8'd0);
        send_pong(8'd255);
        send_pong(8'd0);
        drain();
        write_register(CFG_SAMPLE_SCALE, 8'hFF);    // upper bits must be dropped
        write_register(CFG_SAMPLE_CAP, 8'h80);      // cap reads as zero
        send_pong(8'd255);
        send_pong(8'd0);
        drain();

        // threshold at max: nothing is ever busy, counter never passes 1;
        // a write to the undecoded index must not touch the threshold
        write_register(CFG_BUSY_THRESHOLD, 8'd255);
        write_register(CFG_UNUSED, 8'd0);
        send_pong(8'd255);
        send_pong(8'd255);
        send_pong(8'd0);
        drain();

        // random phases, each with its own register settings
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase % 7 == 0)
                thr = 8'd0;
            else if (phase % 7 == 1)
                thr = 8'd255;
            else
                thr = PEND_W'($urandom_range(254, 0));
            if (phase % 6 == 0)
                scl = 4'd1;
            else if (phase % 6 == 1)
                scl = 4'd15;
            else if (phase % 11 == 4)
                scl = 4'd0;
            else
                scl = SCALE_W'($urandom_range(15, 1));
            if (phase % 4 == 0)
                cp = 7'd127;
            else if (phase % 9 == 2)
                cp = 7'd0;
            else
                cp = SAMPLE_W'($urandom_range(127, 0));
            write_register(CFG_BUSY_THRESHOLD, thr);
            write_register(CFG_SAMPLE_SCALE, {4'($urandom_range(15, 0)), scl});
            write_register(CFG_SAMPLE_CAP, {1'($urandom_range(1, 0)), cp});
            if (phase % 5 == 3)
                write_register(CFG_UNUSED, CFG_DATA_W'($urandom_range(255, 0)));
            calm = (phase % 4 == 2);

            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
                if (cur_threshold == 8'd255 || $urandom_range(99) >= 80) begin
                    // noise: any pending count
                    send_pong(PEND_W'($urandom_range(255, 0)));
                end else if (phase == 3) begin
                    // runs long enough to carry the counter up to or through its wrap
                    send_burst($urandom_range(258, 250));
                end else begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(40, 13)
                                                   : $urandom_range(12, 0);
                    send_burst(len);
                end
            end
            drain();
            phase++;
        end

        if (error_count == 0 && results_owed == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
